[hw/rtl/apcs_pkg.sv]
// shared types and character constants for the ascii port command slave
package apcs_pkg;

    // frame parser phase
    typedef enum logic {
        PH_HUNT  = 1'b0,
        PH_FRAME = 1'b1
    } phase_t;

    // command mnemonic seen at the start of the frame
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } kind_t;

    typedef logic [3:0] digit_t;
    typedef logic [7:0] char_t;

    // ascii characters
    localparam char_t CH_S     = 8'h53;
    localparam char_t CH_Y     = 8'h59;
    localparam char_t CH_R     = 8'h52;
    localparam char_t CH_W     = 8'h57;
    localparam char_t CH_D     = 8'h44;
    localparam char_t CH_A     = 8'h41;
    localparam char_t CH_COMMA = 8'h2C;
    localparam char_t CH_0     = 8'h30;
    localparam char_t CH_9     = 8'h39;

    // upper nibble of an ascii digit
    localparam logic [3:0] DIGIT_HI = 4'h3;

    // content lengths needed for a complete command
    localparam int READ_MIN_LEN  = 6;
    localparam int WRITE_MIN_LEN = 11;

    // content position given to bytes from 12 on, so that nothing parses them
    localparam logic [3:0] POS_IGNORE = 4'd15;

    // reply byte positions
    localparam logic [3:0] IDX_FIRST   = 4'd0;
    localparam logic [3:0] IDX_COMMA1  = 4'd5;
    localparam logic [3:0] IDX_UNITS   = 4'd7;
    localparam logic [3:0] IDX_WR_LAST = 4'd8;
    localparam logic [3:0] IDX_RD_LAST = 4'd13;

endpackage

[hw/rtl/ascii_port_command_slave.sv]
// ascii port command slave: frame parser, port store and reply sequencer
//
// Usage:
//   s_ group carries received ascii bytes, one per transaction. Bytes are
//   dropped until an 'S' opens a frame; the frame closes on the next 'S' or
//   after MAX_FRAME content bytes. "RDA,pp" replies "SYRDA,pp,vvvvS" and
//   "WRA,pp,vvvv" stores the value and replies "SYWRA,pS". Malformed frames
//   and ports of PORT_COUNT or more give no reply.
//   m_ group carries the reply bytes; m_tlast marks the closing 'S'.
// Latency and throughput:
//   one input byte per cycle while no reply is pending. The first reply byte
//   is valid the cycle after the byte that closes the frame; a reply is 8, 9
//   or 14 transactions, one per cycle while m_tready is high, and s_tready
//   is low until its last byte is taken (a new byte may enter in that same
//   cycle); the reply sequencer index steps through the reply bytes.
// Reset:
//   synchronous, active low; the parser hunts for 'S' and every port reads
//   as 0000 through per-entry valid bits, so no clearing pass is needed.
// Stalls:
//   when m_tready is low the current reply byte holds and input stays held.
module ascii_port_command_slave #(
    parameter int PORT_COUNT = 100,
    parameter int MAX_FRAME  = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input bytes
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    // reply bytes
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] tx_byte
    output logic       m_tlast
);

    localparam int ADDR_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAME + 1);

    // parser state
    apcs_pkg::phase_t     phase_reg, phase_next;
    apcs_pkg::kind_t      kind_reg, kind_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    apcs_pkg::digit_t     tens_reg, tens_next;
    apcs_pkg::digit_t     units_reg, units_next;
    logic [15:0]          val_reg, val_next;
    logic                 bad_reg, bad_next;

    // reply sequencer state
    logic                 busy_reg, busy_next;
    logic [3:0]           idx_reg, idx_next;
    logic                 rd_cmd_reg, rd_cmd_next;
    apcs_pkg::digit_t     out_tens_reg, out_tens_next;
    apcs_pkg::digit_t     out_units_reg, out_units_next;

    // port store
    logic [15:0]           mem [PORT_COUNT];
    logic [PORT_COUNT-1:0] vld_reg;
    logic [15:0]           rd_val_reg;
    logic                  rd_vld_reg;

    // combinational helpers
    logic                 in_acc, out_acc, is_s, is_dig, finish, ok;
    logic                 wr_en, rd_en, last_byte;
    logic [3:0]           pos;
    apcs_pkg::digit_t     dig;
    logic [6:0]           port_bin;
    logic [ADDR_W-1:0]    addr;
    logic [15:0]          shown_val;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign is_s    = (s_tdata == apcs_pkg::CH_S);
    assign is_dig  = (s_tdata >= apcs_pkg::CH_0) && (s_tdata <= apcs_pkg::CH_9);
    assign dig     = s_tdata[3:0];
    assign pos     = (count_reg < CNT_W'(12)) ? count_reg[3:0] : apcs_pkg::POS_IGNORE;

    // input is held while a reply is out, except as its last byte leaves
    assign s_tready = !busy_reg || (out_acc && last_byte);

    // parser: next state for one accepted byte
    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        count_next = count_reg;
        tens_next  = tens_reg;
        units_next = units_reg;
        val_next   = val_reg;
        bad_next   = bad_reg;
        finish     = 1'b0;
        if (in_acc) begin
            case (phase_reg)
                apcs_pkg::PH_HUNT: begin
                    if (is_s) begin
                        phase_next = apcs_pkg::PH_FRAME;
                        kind_next  = apcs_pkg::KIND_NONE;
                        count_next = '0;
                        tens_next  = '0;
                        units_next = '0;
                        val_next   = '0;
                        bad_next   = 1'b0;
                    end
                end
                apcs_pkg::PH_FRAME: begin
                    if (is_s) begin
                        finish = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        finish     = (count_reg == CNT_W'(MAX_FRAME - 1));
                        case (pos)
                            4'd0: begin
                                if (s_tdata == apcs_pkg::CH_R) begin
                                    kind_next = apcs_pkg::KIND_READ;
                                end else if (s_tdata == apcs_pkg::CH_W) begin
                                    kind_next = apcs_pkg::KIND_WRITE;
                                end else begin
                                    kind_next = apcs_pkg::KIND_NONE;
                                    bad_next  = 1'b1;
                                end
                            end
                            4'd1: begin
                                if (s_tdata != ((kind_reg == apcs_pkg::KIND_READ) ?
                                                apcs_pkg::CH_D : apcs_pkg::CH_R)) begin
                                    bad_next = 1'b1;
                                end
                            end
                            4'd2: begin
                                if (s_tdata != apcs_pkg::CH_A) bad_next = 1'b1;
                            end
                            4'd3: begin
                                if (s_tdata != apcs_pkg::CH_COMMA) bad_next = 1'b1;
                            end
                            4'd4, 4'd5: begin
                                if (is_dig) begin
                                    tens_next  = units_reg;
                                    units_next = dig;
                                end else begin
                                    bad_next = 1'b1;
                                end
                            end
                            4'd6: begin
                                if (kind_reg == apcs_pkg::KIND_WRITE) begin
                                    if (s_tdata != apcs_pkg::CH_COMMA) bad_next = 1'b1;
                                end else if (is_dig) begin
                                    bad_next = 1'b1;
                                end
                            end
                            4'd7, 4'd8, 4'd9, 4'd10: begin
                                if (kind_reg == apcs_pkg::KIND_WRITE) begin
                                    if (is_dig) val_next = {val_reg[11:0], dig};
                                    else bad_next = 1'b1;
                                end
                            end
                            4'd11: begin
                                if (kind_reg == apcs_pkg::KIND_WRITE && is_dig) begin
                                    bad_next = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (finish) phase_next = apcs_pkg::PH_HUNT;
                end
                default: phase_next = apcs_pkg::PH_HUNT;
            endcase
        end
    end

    // judge the frame on the byte that closes it
    assign port_bin = {tens_next, 3'b000} + {2'b00, tens_next, 1'b0} + {3'b000, units_next};
    assign addr     = port_bin[ADDR_W-1:0];
    assign ok = finish && !bad_next && (port_bin < 7'(PORT_COUNT)) &&
                ((kind_next == apcs_pkg::KIND_READ &&
                  count_next >= CNT_W'(apcs_pkg::READ_MIN_LEN)) ||
                 (kind_next == apcs_pkg::KIND_WRITE &&
                  count_next >= CNT_W'(apcs_pkg::WRITE_MIN_LEN)));
    assign rd_en = ok && (kind_next == apcs_pkg::KIND_READ);
    assign wr_en = ok && (kind_next == apcs_pkg::KIND_WRITE);

    // reply byte selection
    assign shown_val = rd_vld_reg ? rd_val_reg : 16'h0000;
    assign last_byte = rd_cmd_reg ? (idx_reg == apcs_pkg::IDX_RD_LAST)
                                  : (idx_reg == apcs_pkg::IDX_WR_LAST);
    assign m_tvalid  = busy_reg;
    assign m_tlast   = last_byte;

    always_comb begin
        case (idx_reg)
            4'd0:    m_tdata = apcs_pkg::CH_S;
            4'd1:    m_tdata = apcs_pkg::CH_Y;
            4'd2:    m_tdata = rd_cmd_reg ? apcs_pkg::CH_R : apcs_pkg::CH_W;
            4'd3:    m_tdata = rd_cmd_reg ? apcs_pkg::CH_D : apcs_pkg::CH_R;
            4'd4:    m_tdata = apcs_pkg::CH_A;
            4'd5:    m_tdata = apcs_pkg::CH_COMMA;
            4'd6:    m_tdata = {apcs_pkg::DIGIT_HI, out_tens_reg};
            4'd7:    m_tdata = {apcs_pkg::DIGIT_HI, out_units_reg};
            4'd8:    m_tdata = rd_cmd_reg ? apcs_pkg::CH_COMMA : apcs_pkg::CH_S;
            4'd9:    m_tdata = {apcs_pkg::DIGIT_HI, shown_val[15:12]};
            4'd10:   m_tdata = {apcs_pkg::DIGIT_HI, shown_val[11:8]};
            4'd11:   m_tdata = {apcs_pkg::DIGIT_HI, shown_val[7:4]};
            4'd12:   m_tdata = {apcs_pkg::DIGIT_HI, shown_val[3:0]};
            default: m_tdata = apcs_pkg::CH_S;
        endcase
    end

    // reply sequencer: a new reply loads over the end of the previous one
    always_comb begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        rd_cmd_next    = rd_cmd_reg;
        out_tens_next  = out_tens_reg;
        out_units_next = out_units_reg;
        if (out_acc) begin
            if (last_byte) begin
                busy_next = 1'b0;
            end else if (idx_reg == apcs_pkg::IDX_COMMA1 && !rd_cmd_reg &&
                         out_tens_reg == 4'd0) begin
                // single-digit port in a write reply
                idx_next = apcs_pkg::IDX_UNITS;
            end else begin
                idx_next = idx_reg + 4'd1;
            end
        end
        if (ok) begin
            busy_next      = 1'b1;
            idx_next       = apcs_pkg::IDX_FIRST;
            rd_cmd_next    = (kind_next == apcs_pkg::KIND_READ);
            out_tens_next  = tens_next;
            out_units_next = units_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= apcs_pkg::PH_HUNT;
            kind_reg  <= apcs_pkg::KIND_NONE;
            count_reg <= '0;
            bad_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            idx_reg   <= apcs_pkg::IDX_FIRST;
            vld_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            bad_reg   <= bad_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            if (wr_en) vld_reg[addr] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        tens_reg      <= tens_next;
        units_reg     <= units_next;
        val_reg       <= val_next;
        rd_cmd_reg    <= rd_cmd_next;
        out_tens_reg  <= out_tens_next;
        out_units_reg <= out_units_next;
    end

    // port store, values kept as four decimal digits
    always_ff @(posedge aclk) begin
        if (wr_en) mem[addr] <= val_next;
        if (rd_en) begin
            rd_val_reg <= mem[addr];
            rd_vld_reg <= vld_reg[addr];
        end
    end

endmodule

[sim/apcs_reply_checker.sv]
// reply checker: predicts the reply bytes of the port command slave and compares them
`timescale 1ns / 1ps

module apcs_reply_checker #(
    parameter int PORT_COUNT = 100,
    parameter int MAX_FRAME  = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] tx_byte
    input  logic       m_tlast,
    output int         mismatch_count,
    output int         bytes_pending,
    output int         replies_done
);

    typedef struct packed {
        apcs_pkg::char_t data;
        logic            last;
    } reply_byte_t;

    // reply bytes predicted but not yet seen on the m_ group
    reply_byte_t pending_reply[$];
    reply_byte_t oldest;

    // predicted parser state and port store
    apcs_pkg::phase_t phase;
    apcs_pkg::kind_t  cmd;
    int unsigned      body_len;
    logic [6:0]       port_acc;
    logic [13:0]      value_acc;
    logic             malformed;
    logic [13:0]      port_mirror [PORT_COUNT];

    int mismatches = 0;
    int replies    = 0;

    function automatic bit is_digit(apcs_pkg::char_t c);
        return c >= apcs_pkg::CH_0 && c <= apcs_pkg::CH_9;
    endfunction

    function automatic apcs_pkg::char_t digit_of(int unsigned v);
        return apcs_pkg::CH_0 + apcs_pkg::char_t'(v % 10);
    endfunction

    task automatic push_reply(apcs_pkg::char_t c, logic last);
        pending_reply.push_back('{data: c, last: last});
    endtask

    task automatic clear_frame();
        cmd       = apcs_pkg::KIND_NONE;
        body_len  = 0;
        port_acc  = '0;
        value_acc = '0;
        malformed = 1'b0;
    endtask

    // judge a finished frame and queue its reply
    task automatic close_frame();
        logic [13:0] v;
        bit          ok;
        ok = !malformed && port_acc < PORT_COUNT &&
             ((cmd == apcs_pkg::KIND_READ && body_len >= apcs_pkg::READ_MIN_LEN) ||
              (cmd == apcs_pkg::KIND_WRITE && body_len >= apcs_pkg::WRITE_MIN_LEN));
        if (ok && cmd == apcs_pkg::KIND_READ) begin
            v = port_mirror[port_acc];
            push_reply(apcs_pkg::CH_S, 1'b0);
            push_reply(apcs_pkg::CH_Y, 1'b0);
            push_reply(apcs_pkg::CH_R, 1'b0);
            push_reply(apcs_pkg::CH_D, 1'b0);
            push_reply(apcs_pkg::CH_A, 1'b0);
            push_reply(apcs_pkg::CH_COMMA, 1'b0);
            push_reply(digit_of(port_acc / 10), 1'b0);
            push_reply(digit_of(port_acc), 1'b0);
            push_reply(apcs_pkg::CH_COMMA, 1'b0);
            push_reply(digit_of(v / 1000), 1'b0);
            push_reply(digit_of(v / 100), 1'b0);
            push_reply(digit_of(v / 10), 1'b0);
            push_reply(digit_of(v), 1'b0);
            push_reply(apcs_pkg::CH_S, 1'b1);
        end else if (ok && cmd == apcs_pkg::KIND_WRITE) begin
            port_mirror[port_acc] = value_acc;
            push_reply(apcs_pkg::CH_S, 1'b0);
            push_reply(apcs_pkg::CH_Y, 1'b0);
            push_reply(apcs_pkg::CH_W, 1'b0);
            push_reply(apcs_pkg::CH_R, 1'b0);
            push_reply(apcs_pkg::CH_A, 1'b0);
            push_reply(apcs_pkg::CH_COMMA, 1'b0);
            // port written without leading zero
            if (port_acc >= 10)
                push_reply(digit_of(port_acc / 10), 1'b0);
            push_reply(digit_of(port_acc), 1'b0);
            push_reply(apcs_pkg::CH_S, 1'b1);
        end
        phase = apcs_pkg::PH_HUNT;
    endtask

    // check one content byte at its position in the frame
    task automatic parse_content(int unsigned p, apcs_pkg::char_t c);
        case (p)
            0: begin
                if (c == apcs_pkg::CH_R) cmd = apcs_pkg::KIND_READ;
                else if (c == apcs_pkg::CH_W) cmd = apcs_pkg::KIND_WRITE;
                else begin
                    cmd       = apcs_pkg::KIND_NONE;
                    malformed = 1'b1;
                end
            end
            1: begin
                if (c != ((cmd == apcs_pkg::KIND_READ) ? apcs_pkg::CH_D : apcs_pkg::CH_R))
                    malformed = 1'b1;
            end
            2: if (c != apcs_pkg::CH_A) malformed = 1'b1;
            3: if (c != apcs_pkg::CH_COMMA) malformed = 1'b1;
            4, 5: begin
                if (is_digit(c))
                    port_acc = 7'(int'(port_acc) * 10 + int'(c - apcs_pkg::CH_0));
                else malformed = 1'b1;
            end
            6: begin
                if (cmd == apcs_pkg::KIND_WRITE) begin
                    if (c != apcs_pkg::CH_COMMA) malformed = 1'b1;
                end else if (is_digit(c)) begin
                    malformed = 1'b1;
                end
            end
            7, 8, 9, 10: begin
                if (cmd == apcs_pkg::KIND_WRITE) begin
                    if (is_digit(c))
                        value_acc = 14'(int'(value_acc) * 10 + int'(c - apcs_pkg::CH_0));
                    else malformed = 1'b1;
                end
            end
            11: if (cmd == apcs_pkg::KIND_WRITE && is_digit(c)) malformed = 1'b1;
            default: ;
        endcase
    endtask

    task automatic predict_rx_byte(apcs_pkg::char_t b);
        if (phase == apcs_pkg::PH_HUNT) begin
            if (b == apcs_pkg::CH_S) begin
                clear_frame();
                phase = apcs_pkg::PH_FRAME;
            end
        end else if (b == apcs_pkg::CH_S) begin
            close_frame();
        end else begin
            parse_content(body_len, b);
            body_len++;
            if (body_len >= MAX_FRAME)
                close_frame();
        end
    endtask

    // compare reply transactions first, then feed the accepted input byte
    always @(posedge aclk) begin
        if (!aresetn) begin
            phase = apcs_pkg::PH_HUNT;
            clear_frame();
            for (int i = 0; i < PORT_COUNT; i++)
                port_mirror[i] = '0;
            pending_reply.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_reply.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected reply byte %h last %b",
                                 $time, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    oldest = pending_reply.pop_front();
                    if (m_tdata !== oldest.data || m_tlast !== oldest.last) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch, expected byte %h last %b, got byte %h last %b",
                                     $time, oldest.data, oldest.last, m_tdata, m_tlast);
                        mismatches++;
                    end
                    if (oldest.last)
                        replies++;
                end
            end
            if (s_tvalid && s_tready)
                predict_rx_byte(s_tdata);
        end
        mismatch_count <= mismatches;
        bytes_pending  <= pending_reply.size();
        replies_done   <= replies;
    end

endmodule

[sim/tb_top.sv]
// testbench top: byte stimulus, reply backpressure and verdict for the port command slave
`timescale 1ns / 1ps

module tb_top;

    localparam int PORT_COUNT     = 100;
    localparam int MAX_FRAME      = 64;
    localparam int DIRECTED_BYTES = 25;
    localparam int RANDOM_BYTES   = 345;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    localparam apcs_pkg::char_t CH_SPACE = 8'h20;
    localparam apcs_pkg::char_t CH_PLUS  = 8'h2B;
    localparam apcs_pkg::char_t CH_MINUS = 8'h2D;

    typedef enum int {
        FR_WRITE, FR_READ, FR_BROKEN, FR_NOISE, FR_EMPTY, FR_LONG
    } frame_sel_t;

    typedef enum int {
        MUT_BYTE, MUT_EXTRA_DIGIT, MUT_SIGN, MUT_CUT, MUT_DIGIT_COUNT
    } mutation_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] rx_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] tx_byte
    logic       m_tlast;

    int mismatch_count;
    int bytes_pending;
    int replies_done;

    int idle_cycles    = 0;
    int bytes_sent     = 0;
    int frames_sent    = 0;
    int broken_frames  = 0;
    int long_frames    = 0;
    bit long_hold_done = 1'b0;

    // bytes of the frame being built
    apcs_pkg::char_t frame_q[$];

    ascii_port_command_slave #(
        .PORT_COUNT(PORT_COUNT),
        .MAX_FRAME(MAX_FRAME)
    ) uut (.*);

    apcs_reply_checker #(
        .PORT_COUNT(PORT_COUNT),
        .MAX_FRAME(MAX_FRAME)
    ) reply_check (.*);

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // reply side backpressure: short stalls, quiet stretches, one long hold-off
    initial begin
        int hold_left;
        int quiet_left;
        int r;
        hold_left  = 0;
        quiet_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (quiet_left > 0) begin
                quiet_left--;
                m_tready <= 1'b1;
            end else if (!long_hold_done && replies_done >= 3 && m_tvalid) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    quiet_left = $urandom_range(40, 150);
                    m_tready <= 1'b1;
                end else if (r < 5) begin
                    hold_left = $urandom_range(8, 30);
                    m_tready <= 1'b0;
                end else if (r < 25) begin
                    hold_left = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    function automatic apcs_pkg::char_t digit_char(int v);
        return apcs_pkg::CH_0 + apcs_pkg::char_t'(v % 10);
    endfunction

    // one input transaction, with an optional random gap before it
    task automatic send_byte(apcs_pkg::char_t b, bit steady);
        int gap;
        int r;
        r   = $urandom_range(0, 99);
        gap = (steady || r < 70) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 25);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame(bit steady);
        foreach (frame_q[i])
            send_byte(frame_q[i], steady);
        frame_q.delete();
        frames_sent++;
    endtask

    // stop offering and wait until every predicted reply byte has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bytes_pending != 0) @(posedge aclk);
    endtask

    // opening S and a well-formed read or write command
    task automatic add_cmd(apcs_pkg::kind_t k, int port, int value);
        frame_q.push_back(apcs_pkg::CH_S);
        frame_q.push_back(k == apcs_pkg::KIND_READ ? apcs_pkg::CH_R : apcs_pkg::CH_W);
        frame_q.push_back(k == apcs_pkg::KIND_READ ? apcs_pkg::CH_D : apcs_pkg::CH_R);
        frame_q.push_back(apcs_pkg::CH_A);
        frame_q.push_back(apcs_pkg::CH_COMMA);
        frame_q.push_back(digit_char(port / 10));
        frame_q.push_back(digit_char(port));
        if (k == apcs_pkg::KIND_WRITE) begin
            frame_q.push_back(apcs_pkg::CH_COMMA);
            for (int d = 1000; d > 0; d /= 10)
                frame_q.push_back(digit_char(value / d));
        end
    endtask

    // bytes other than S, the first one also not a digit
    task automatic add_filler(int count);
        apcs_pkg::char_t c;
        for (int i = 0; i < count; i++) begin
            do c = apcs_pkg::char_t'($urandom_range(0, 255));
            while (c == apcs_pkg::CH_S ||
                   (i == 0 && c >= apcs_pkg::CH_0 && c <= apcs_pkg::CH_9));
            frame_q.push_back(c);
        end
    endtask

    // stimulus and verdict
    initial begin
        int              r;
        int              frame_idx;
        int              port;
        int              value;
        int              body;
        int              keep;
        int              start_bytes;
        apcs_pkg::kind_t kind;
        frame_sel_t      sel;
        mutation_t       how;
        apcs_pkg::char_t c;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: byte extremes while hunting, top port and value, readback, empty frame
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        send_frame(1'b0);
        add_cmd(apcs_pkg::KIND_WRITE, 99, 9999);
        frame_q.push_back(apcs_pkg::CH_S);
        send_frame(1'b0);
        add_cmd(apcs_pkg::KIND_READ, 99, 0);
        frame_q.push_back(apcs_pkg::CH_S);
        send_frame(1'b0);
        frame_q.push_back(apcs_pkg::CH_S);
        frame_q.push_back(apcs_pkg::CH_S);
        send_frame(1'b0);
        wait_drained();

        // random frames, mostly well formed
        start_bytes = bytes_sent;
        frame_idx   = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            port  = $urandom_range(0, 1) ? $urandom_range(0, 11) : $urandom_range(0, 99);
            value = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 9999 : 0)
                                                : $urandom_range(0, 9999);
            kind  = $urandom_range(0, 1) ? apcs_pkg::KIND_READ : apcs_pkg::KIND_WRITE;
            how   = mutation_t'($urandom_range(0, 4));
            r     = $urandom_range(0, 99);
            sel   = (r < 30) ? FR_WRITE : (r < 55) ? FR_READ : (r < 78) ? FR_BROKEN :
                    (r < 88) ? FR_NOISE : (r < 93) ? FR_EMPTY : FR_LONG;
            // make sure a signed port and an over-length frame come early
            if (frame_idx == 2) begin
                sel = FR_BROKEN;
                how = MUT_SIGN;
            end
            if (frame_idx == 4)
                sel = FR_LONG;
            if (frame_idx == 12)
                wait_drained();

            case (sel)
                FR_WRITE, FR_READ: begin
                    add_cmd(sel == FR_READ ? apcs_pkg::KIND_READ : apcs_pkg::KIND_WRITE,
                            port, value);
                    if ($urandom_range(0, 2) == 0)
                        add_filler($urandom_range(1, 5));
                    frame_q.push_back(apcs_pkg::CH_S);
                end
                FR_BROKEN: begin
                    add_cmd(kind, port, value);
                    body = frame_q.size() - 1;
                    case (how)
                        MUT_BYTE:
                            frame_q[1 + $urandom_range(0, body - 1)] =
                                apcs_pkg::char_t'($urandom_range(0, 255));
                        MUT_EXTRA_DIGIT:
                            frame_q.push_back(digit_char($urandom_range(0, 9)));
                        MUT_SIGN: begin
                            r = $urandom_range(0, 2);
                            c = (r == 0) ? CH_SPACE : (r == 1) ? CH_PLUS : CH_MINUS;
                            if ($urandom_range(0, 1)) frame_q[5] = c;
                            else frame_q.insert(5, c);
                        end
                        MUT_CUT: begin
                            keep = $urandom_range(0, body - 1);
                            while (frame_q.size() > keep + 1) void'(frame_q.pop_back());
                        end
                        MUT_DIGIT_COUNT: begin
                            // one value digit short, or a three-digit port
                            if (kind == apcs_pkg::KIND_WRITE && $urandom_range(0, 1))
                                frame_q.delete(8 + $urandom_range(0, 3));
                            else
                                frame_q.insert(5, digit_char($urandom_range(0, 9)));
                        end
                        default: ;
                    endcase
                    frame_q.push_back(apcs_pkg::CH_S);
                    broken_frames++;
                end
                FR_NOISE:
                    repeat ($urandom_range(1, 6))
                        frame_q.push_back(apcs_pkg::char_t'($urandom_range(0, 255)));
                FR_EMPTY: begin
                    frame_q.push_back(apcs_pkg::CH_S);
                    frame_q.push_back(apcs_pkg::CH_S);
                end
                default: begin
                    // content padded to exactly MAX_FRAME bytes, then bytes to hunt through
                    add_cmd(kind, port, value);
                    add_filler(MAX_FRAME + 1 - frame_q.size());
                    add_filler($urandom_range(1, 3));
                    long_frames++;
                end
            endcase
            send_frame($urandom_range(0, 3) == 0);
            frame_idx++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d bytes in %0d frames (%0d broken, %0d over-length),",
                 bytes_sent, frames_sent, broken_frames, long_frames);
        $display("%0d replies checked, stalls on both sides, one reply hold-off of %0d cycles",
                 replies_done, LONG_HOLD);
        if (mismatch_count == 0 && bytes_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
